// ----- rtl/first_fit_page_run_allocator_macros.svh -----
// Assertion macros used by the allocator controller.
`ifndef FIRST_FIT_PAGE_RUN_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_PAGE_RUN_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFPRA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FFPRA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ffpra_pkg.sv -----
package ffpra_pkg;

    localparam int NUM_PAGES = 1024;
    localparam int PAGE_W    = $clog2(NUM_PAGES);
    localparam int PTR_W     = PAGE_W + 1;
    localparam int SUM_W     = PTR_W + 1;
    localparam int COUNT_W   = 11;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int CFG_W     = 10;

    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
    localparam logic [OP_W-1:0] OP_RESIZE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOM     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NULL    = 2'd3;

    localparam logic CFG_FIRST = 1'b0;
    localparam logic CFG_LAST  = 1'b1;

    typedef struct packed {
        logic               in_use;
        logic               is_head;
        logic [COUNT_W-1:0] run;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LOOKUP,
        PH_SEARCH,
        PH_CHECK,
        PH_COUNT,
        PH_MARK,
        PH_CLEAR
    } phase_t;

    typedef enum logic [2:0] {
        RG_LOOKUP,
        RG_USABLE,
        RG_NEW_TAIL,
        RG_OLD_RUN,
        RG_SHRINK,
        RG_EXT,
        RG_ALL
    } range_t;

    typedef struct packed {
        logic                latch;
        phase_t              phase;
        range_t              range;
        logic                take_found;
        logic                write_head;
        logic                set_status;
        logic [STATUS_W-1:0] status;
        logic                set_result;
        logic                publish;
    } cmd_t;

    typedef struct packed {
        logic            busy;
        logic [OP_W-1:0] op;
        logic            n_zero;
        logic            head_zero;
        logic            head_ok;
        logic            n_eq_len;
        logic            n_lt_len;
        logic            ext_fits;
        logic            hit;
        logic            fail;
    } sts_t;

endpackage

// ----- rtl/ffpra_ram.sv -----
module ffpra_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/ffpra_datapath.sv -----
module ffpra_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ffpra_pkg::cmd_t                    cmd,
    output ffpra_pkg::sts_t                    sts,
    input  logic [ffpra_pkg::OP_W-1:0]         operation,
    input  logic [ffpra_pkg::COUNT_W-1:0]      page_count,
    input  logic [ffpra_pkg::PAGE_W-1:0]       head_page,
    input  logic                               cfg_valid,
    input  logic                               cfg_index,
    input  logic [ffpra_pkg::CFG_W-1:0]        cfg_data,
    output logic [ffpra_pkg::STATUS_W-1:0]     status,
    output logic [ffpra_pkg::PAGE_W-1:0]       result_page,
    output logic [ffpra_pkg::COUNT_W-1:0]      free_pages
);

    localparam int SW = ffpra_pkg::SUM_W;
    localparam int PW = ffpra_pkg::PTR_W;
    localparam int AW = ffpra_pkg::PAGE_W;

    ffpra_pkg::phase_t                phase_reg;
    logic                             rd_v_reg;
    logic [ffpra_pkg::CFG_W-1:0]      first_reg;
    logic [ffpra_pkg::CFG_W-1:0]      last_reg;

    logic [PW-1:0]                    ptr_reg;
    logic [PW-1:0]                    end_reg;
    logic [AW-1:0]                    rd_a_reg;
    logic [ffpra_pkg::COUNT_W-1:0]    cnt_reg;
    logic [AW-1:0]                    start_reg;
    logic                             hit_reg;
    logic                             fail_reg;
    logic [ffpra_pkg::OP_W-1:0]       op_reg;
    logic [ffpra_pkg::COUNT_W-1:0]    n_reg;
    logic [AW-1:0]                    head_reg;
    logic [AW-1:0]                    target_reg;
    logic [ffpra_pkg::COUNT_W-1:0]    len_reg;
    logic                             head_ok_reg;
    logic [ffpra_pkg::STATUS_W-1:0]   status_reg;
    logic [AW-1:0]                    result_reg;
    logic [ffpra_pkg::STATUS_W-1:0]   status_out_reg;
    logic [AW-1:0]                    result_out_reg;
    logic [ffpra_pkg::COUNT_W-1:0]    free_out_reg;

    logic [AW-1:0]                    lo;
    logic [SW-1:0]                    head_x;
    logic [SW-1:0]                    n_x;
    logic [SW-1:0]                    len_x;
    logic [SW-1:0]                    tgt_x;
    logic [SW-1:0]                    from_sum;
    logic [SW-1:0]                    to_sum;
    logic [PW-1:0]                    rg_from;
    logic [PW-1:0]                    rg_to;

    logic                             start;
    logic                             active;
    logic                             more;
    logic                             read_phase;
    logic                             write_phase;
    logic                             done_now;
    ffpra_pkg::entry_t                rd_entry;
    logic                             free_usable;
    logic                             hit_now;
    logic [ffpra_pkg::COUNT_W-1:0]    cnt_inc;
    logic [AW-1:0]                    run_start;

    logic                             we;
    logic [AW-1:0]                    waddr;
    ffpra_pkg::entry_t                wdata;
    logic [ffpra_pkg::ENTRY_W-1:0]    rdata;

    // A first bound of zero acts as one, since page zero means null.
    assign lo = (first_reg == '0) ? AW'(1) : first_reg;

    assign head_x = SW'(head_reg);
    assign n_x    = SW'(n_reg);
    assign len_x  = SW'(len_reg);
    assign tgt_x  = SW'(target_reg);

    always_comb
    begin
        from_sum = '0;
        to_sum   = SW'(ffpra_pkg::NUM_PAGES);
        unique case (cmd.range)
            ffpra_pkg::RG_LOOKUP:
            begin
                from_sum = head_x;
                to_sum   = head_x + SW'(1);
            end
            ffpra_pkg::RG_USABLE:
            begin
                from_sum = SW'(lo);
                to_sum   = SW'(last_reg) + SW'(1);
            end
            ffpra_pkg::RG_NEW_TAIL:
            begin
                from_sum = tgt_x + SW'(1);
                to_sum   = tgt_x + n_x;
            end
            ffpra_pkg::RG_OLD_RUN:
            begin
                from_sum = head_x;
                to_sum   = head_x + ((len_reg == '0) ? SW'(1) : len_x);
            end
            ffpra_pkg::RG_SHRINK:
            begin
                from_sum = head_x + n_x;
                to_sum   = head_x + len_x;
            end
            ffpra_pkg::RG_EXT:
            begin
                from_sum = head_x + len_x;
                to_sum   = head_x + n_x;
            end
            ffpra_pkg::RG_ALL:
            begin
                from_sum = '0;
                to_sum   = SW'(ffpra_pkg::NUM_PAGES);
            end
            default:
            begin
                from_sum = '0;
                to_sum   = '0;
            end
        endcase
        rg_from = (from_sum > SW'(ffpra_pkg::NUM_PAGES)) ? PW'(ffpra_pkg::NUM_PAGES)
                                                          : from_sum[PW-1:0];
        rg_to   = (to_sum > SW'(ffpra_pkg::NUM_PAGES)) ? PW'(ffpra_pkg::NUM_PAGES)
                                                        : to_sum[PW-1:0];
    end

    assign start       = (cmd.phase != ffpra_pkg::PH_IDLE);
    assign active      = (phase_reg != ffpra_pkg::PH_IDLE);
    assign more        = (ptr_reg < end_reg);
    assign read_phase  = (phase_reg == ffpra_pkg::PH_LOOKUP) ||
                         (phase_reg == ffpra_pkg::PH_SEARCH) ||
                         (phase_reg == ffpra_pkg::PH_CHECK)  ||
                         (phase_reg == ffpra_pkg::PH_COUNT);
    assign write_phase = (phase_reg == ffpra_pkg::PH_MARK) ||
                         (phase_reg == ffpra_pkg::PH_CLEAR);
    assign done_now    = active && !more && !rd_v_reg;

    assign rd_entry    = ffpra_pkg::entry_t'(rdata);
    assign free_usable = !rd_entry.in_use && (rd_a_reg >= lo) && (rd_a_reg <= last_reg);
    assign cnt_inc     = cnt_reg + ffpra_pkg::COUNT_W'(1);
    assign hit_now     = active && rd_v_reg && (phase_reg == ffpra_pkg::PH_SEARCH) &&
                         free_usable && (cnt_inc == n_reg);
    assign run_start   = (cnt_reg == '0) ? rd_a_reg : start_reg;

    always_comb
    begin
        we    = 1'b0;
        waddr = ptr_reg[AW-1:0];
        wdata = '0;
        if (cmd.write_head)
        begin
            we            = 1'b1;
            waddr         = target_reg;
            wdata.in_use  = 1'b1;
            wdata.is_head = 1'b1;
            wdata.run     = n_reg;
        end
        else if (write_phase && more)
        begin
            we           = 1'b1;
            wdata.in_use = (phase_reg == ffpra_pkg::PH_MARK);
        end
    end

    ffpra_ram #(
        .WIDTH (ffpra_pkg::ENTRY_W),
        .DEPTH (ffpra_pkg::NUM_PAGES)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (ptr_reg[AW-1:0]),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ffpra_pkg::PH_IDLE;
            rd_v_reg  <= 1'b0;
            first_reg <= ffpra_pkg::CFG_W'(1);
            last_reg  <= ffpra_pkg::CFG_W'(1023);
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == ffpra_pkg::CFG_FIRST)
                begin
                    first_reg <= cfg_data;
                end
                else
                begin
                    last_reg <= cfg_data;
                end
            end
            if (start)
            begin
                phase_reg <= cmd.phase;
                rd_v_reg  <= 1'b0;
            end
            else if (active)
            begin
                rd_v_reg <= read_phase && more;
                if (done_now || hit_now)
                begin
                    phase_reg <= ffpra_pkg::PH_IDLE;
                end
                if (hit_now)
                begin
                    rd_v_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg     <= operation;
            n_reg      <= page_count;
            head_reg   <= head_page;
            target_reg <= head_page;
            status_reg <= ffpra_pkg::ST_OK;
            result_reg <= '0;
        end
        if (cmd.take_found)
        begin
            target_reg <= start_reg;
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status;
        end
        if (cmd.set_result)
        begin
            result_reg <= target_reg;
        end
        if (cmd.publish)
        begin
            status_out_reg <= status_reg;
            result_out_reg <= result_reg;
            free_out_reg   <= cnt_reg;
        end
        if (start)
        begin
            ptr_reg  <= rg_from;
            end_reg  <= rg_to;
            cnt_reg  <= '0;
            hit_reg  <= 1'b0;
            fail_reg <= 1'b0;
        end
        else if (active)
        begin
            if (more)
            begin
                ptr_reg <= ptr_reg + PW'(1);
            end
            rd_a_reg <= ptr_reg[AW-1:0];
            if (rd_v_reg)
            begin
                unique case (phase_reg)
                    ffpra_pkg::PH_LOOKUP:
                    begin
                        len_reg     <= rd_entry.run;
                        head_ok_reg <= rd_entry.in_use && rd_entry.is_head;
                    end
                    ffpra_pkg::PH_SEARCH:
                    begin
                        if (free_usable)
                        begin
                            start_reg <= run_start;
                            cnt_reg   <= cnt_inc;
                            hit_reg   <= hit_now;
                        end
                        else
                        begin
                            cnt_reg <= '0;
                        end
                    end
                    ffpra_pkg::PH_CHECK:
                    begin
                        if (!free_usable)
                        begin
                            fail_reg <= 1'b1;
                        end
                    end
                    ffpra_pkg::PH_COUNT:
                    begin
                        if (free_usable)
                        begin
                            cnt_reg <= cnt_inc;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        sts.busy      = active;
        sts.op        = op_reg;
        sts.n_zero    = (n_reg == '0);
        sts.head_zero = (head_reg == '0);
        sts.head_ok   = head_ok_reg;
        sts.n_eq_len  = (n_reg == len_reg);
        sts.n_lt_len  = (n_reg < len_reg);
        sts.ext_fits  = ((head_x + n_x) <= SW'(ffpra_pkg::NUM_PAGES));
        sts.hit       = hit_reg;
        sts.fail      = fail_reg;
    end

    assign status      = status_out_reg;
    assign result_page = result_out_reg;
    assign free_pages  = free_out_reg;

endmodule

// ----- rtl/ffpra_ctrl.sv -----
`include "first_fit_page_run_allocator_macros.svh"

module ffpra_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output ffpra_pkg::cmd_t cmd,
    input  ffpra_pkg::sts_t sts
);

    typedef enum logic [3:0] {
        S_WIPE,
        S_WIPE_WAIT,
        S_IDLE,
        S_DISPATCH,
        S_SEARCH,
        S_FOUND,
        S_NEW_TAIL,
        S_LOOKUP,
        S_CHECK,
        S_EXTEND,
        S_SHRINK,
        S_RELEASE,
        S_COUNT,
        S_COUNT_WAIT,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        cmd.phase  = ffpra_pkg::PH_IDLE;
        cmd.range  = ffpra_pkg::RG_ALL;
        state_next = state_reg;
        unique case (state_reg)
            S_WIPE:
            begin
                cmd.phase  = ffpra_pkg::PH_CLEAR;
                cmd.range  = ffpra_pkg::RG_ALL;
                state_next = S_WIPE_WAIT;
            end
            S_WIPE_WAIT:
            begin
                if (!sts.busy)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                priority if (sts.op == ffpra_pkg::OP_ALLOC && !sts.n_zero)
                begin
                    cmd.phase  = ffpra_pkg::PH_SEARCH;
                    cmd.range  = ffpra_pkg::RG_USABLE;
                    state_next = S_SEARCH;
                end
                else if ((sts.op == ffpra_pkg::OP_FREE || sts.op == ffpra_pkg::OP_RESIZE)
                         && !sts.head_zero)
                begin
                    cmd.phase  = ffpra_pkg::PH_LOOKUP;
                    cmd.range  = ffpra_pkg::RG_LOOKUP;
                    state_next = S_LOOKUP;
                end
                else
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ffpra_pkg::ST_NULL;
                    state_next     = S_COUNT;
                end
            end
            S_SEARCH:
            begin
                if (!sts.busy)
                begin
                    if (sts.hit)
                    begin
                        cmd.take_found = 1'b1;
                        state_next     = S_FOUND;
                    end
                    else
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ffpra_pkg::ST_OOM;
                        state_next     = S_COUNT;
                    end
                end
            end
            S_FOUND:
            begin
                cmd.phase  = ffpra_pkg::PH_MARK;
                cmd.range  = ffpra_pkg::RG_NEW_TAIL;
                state_next = S_NEW_TAIL;
            end
            S_NEW_TAIL:
            begin
                if (!sts.busy)
                begin
                    cmd.write_head = 1'b1;
                    cmd.set_result = 1'b1;
                    if (sts.op == ffpra_pkg::OP_RESIZE)
                    begin
                        cmd.phase  = ffpra_pkg::PH_CLEAR;
                        cmd.range  = ffpra_pkg::RG_OLD_RUN;
                        state_next = S_RELEASE;
                    end
                    else
                    begin
                        state_next = S_COUNT;
                    end
                end
            end
            S_LOOKUP:
            begin
                if (!sts.busy)
                begin
                    priority if (!sts.head_ok)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ffpra_pkg::ST_INVALID;
                        state_next     = S_COUNT;
                    end
                    else if (sts.op == ffpra_pkg::OP_FREE || sts.n_zero)
                    begin
                        cmd.phase  = ffpra_pkg::PH_CLEAR;
                        cmd.range  = ffpra_pkg::RG_OLD_RUN;
                        state_next = S_RELEASE;
                    end
                    else if (sts.n_eq_len)
                    begin
                        cmd.set_result = 1'b1;
                        state_next     = S_COUNT;
                    end
                    else if (sts.n_lt_len)
                    begin
                        cmd.phase  = ffpra_pkg::PH_CLEAR;
                        cmd.range  = ffpra_pkg::RG_SHRINK;
                        state_next = S_SHRINK;
                    end
                    else if (!sts.ext_fits)
                    begin
                        cmd.phase  = ffpra_pkg::PH_SEARCH;
                        cmd.range  = ffpra_pkg::RG_USABLE;
                        state_next = S_SEARCH;
                    end
                    else
                    begin
                        cmd.phase  = ffpra_pkg::PH_CHECK;
                        cmd.range  = ffpra_pkg::RG_EXT;
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (!sts.busy)
                begin
                    if (sts.fail)
                    begin
                        cmd.phase  = ffpra_pkg::PH_SEARCH;
                        cmd.range  = ffpra_pkg::RG_USABLE;
                        state_next = S_SEARCH;
                    end
                    else
                    begin
                        cmd.phase  = ffpra_pkg::PH_MARK;
                        cmd.range  = ffpra_pkg::RG_EXT;
                        state_next = S_EXTEND;
                    end
                end
            end
            S_EXTEND, S_SHRINK:
            begin
                if (!sts.busy)
                begin
                    cmd.write_head = 1'b1;
                    cmd.set_result = 1'b1;
                    state_next     = S_COUNT;
                end
            end
            S_RELEASE:
            begin
                if (!sts.busy)
                begin
                    state_next = S_COUNT;
                end
            end
            S_COUNT:
            begin
                cmd.phase  = ffpra_pkg::PH_COUNT;
                cmd.range  = ffpra_pkg::RG_USABLE;
                state_next = S_COUNT_WAIT;
            end
            S_COUNT_WAIT:
            begin
                if (!sts.busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_WIPE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `FFPRA_ASSERT_NOW(a_idle_quiet, state_reg == S_IDLE, !sts.busy, "datapath busy while idle")
    `FFPRA_ASSERT_NEXT(a_accept_dispatch, in_valid && in_ready, state_reg == S_DISPATCH, "request not dispatched")
    `FFPRA_ASSERT_NOW(a_start_free, cmd.phase != ffpra_pkg::PH_IDLE, !sts.busy, "phase started while busy")
    `FFPRA_ASSERT_NEXT(a_publish_valid, cmd.publish, out_valid_reg, "published result not valid")

endmodule

// ----- rtl/first_fit_page_run_allocator.sv -----
// Channel  Handshake               Payload
// in       in_valid / in_ready     operation, page_count, head_page
// out      out_valid / out_ready   status, result_page, free_pages
// cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One request at a time; each walks the page table one entry per cycle through the
// one table memory. An allocate walks the search span, the new run's tail and the
// usable span; a resize that moves its run adds the head lookup, the extension check
// (when the extension would fit) and the release of the old run. The final free count
// always walks the whole usable span.
// After reset the table is cleared with in_ready low.
// A finished result waits in the output register; a new request is taken meanwhile.
module first_fit_page_run_allocator (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [ffpra_pkg::OP_W-1:0]         operation,
    input  logic [ffpra_pkg::COUNT_W-1:0]      page_count,
    input  logic [ffpra_pkg::PAGE_W-1:0]       head_page,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [ffpra_pkg::STATUS_W-1:0]     status,
    output logic [ffpra_pkg::PAGE_W-1:0]       result_page,
    output logic [ffpra_pkg::COUNT_W-1:0]      free_pages,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_index,
    input  logic [ffpra_pkg::CFG_W-1:0]        cfg_data
);

    ffpra_pkg::cmd_t cmd;
    ffpra_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    ffpra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    ffpra_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .operation   (operation),
        .page_count  (page_count),
        .head_page   (head_page),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .status      (status),
        .result_page (result_page),
        .free_pages  (free_pages)
    );

endmodule

// ----- bench/tb_first_fit_page_run_allocator.sv -----
module tb_first_fit_page_run_allocator;
    import ffpra_pkg::*;

    localparam int CYCLE_LIMIT = 20000000;
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [COUNT_W-1:0]  count;
        logic [PAGE_W-1:0]   head;
        logic                known;
        logic [STATUS_W-1:0] st;
        logic [PAGE_W-1:0]   page;
        logic [COUNT_W-1:0]  nfree;
    } stim_row_t;

    typedef struct packed {
        logic [STATUS_W-1:0] st;
        logic [PAGE_W-1:0]   page;
        logic [COUNT_W-1:0]  nfree;
    } outcome_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [OP_W-1:0] operation;
    logic [COUNT_W-1:0] page_count;
    logic [PAGE_W-1:0] head_page;
    logic out_valid;
    logic out_ready;
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0] result_page;
    logic [COUNT_W-1:0] free_pages;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_index;
    logic [CFG_W-1:0] cfg_data;

    first_fit_page_run_allocator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .page_count(page_count), .head_page(head_page),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .result_page(result_page), .free_pages(free_pages),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    logic [CFG_W-1:0] bound_lo;
    logic [CFG_W-1:0] bound_hi;
    logic pg_used [NUM_PAGES];
    logic pg_head [NUM_PAGES];
    int unsigned pg_run [NUM_PAGES];
    int unsigned free_total;

    outcome_t pending_outcomes[$];
    outcome_t typed_outcomes[$];
    logic typed_known[$];
    int errors;
    int sender_idle;
    int receiver_idle;
    int hold_off;
    int results_seen;
    int cycles;
    int live_heads[$];

    function automatic int lo_page();
        return (bound_lo == 0) ? 1 : int'(bound_lo);
    endfunction

    function automatic bit page_free_usable(int p);
        return p < NUM_PAGES && p >= lo_page() && p <= int'(bound_hi) && !pg_used[p];
    endfunction

    function automatic void count_free();
        free_total = 0;
        for (int p = 0; p < NUM_PAGES; p++)
        begin
            if (page_free_usable(p))
                free_total++;
        end
    endfunction

    function automatic bit span_free(int a, int b);
        for (int p = a; p < b; p++)
        begin
            if (!page_free_usable(p))
                return 0;
        end
        return 1;
    endfunction

    function automatic void set_span(int a, int b, bit used);
        for (int p = a; p < b && p < NUM_PAGES; p++)
        begin
            pg_used[p] = used;
            pg_head[p] = 0;
            pg_run[p] = 0;
        end
    endfunction

    function automatic int first_fit(int n);
        for (int i = lo_page(); i <= int'(bound_hi); i++)
        begin
            if (span_free(i, i + n))
                return i;
        end
        return 0;
    endfunction

    function automatic void place_run(int h, int n);
        set_span(h + 1, h + n, 1);
        pg_used[h] = 1;
        pg_head[h] = 1;
        pg_run[h] = n & 11'h7ff;
    endfunction

    function automatic void drop_run(int h);
        set_span(h, h + int'(pg_run[h]), 0);
        set_span(h, h + 1, 0);
    endfunction

    function automatic outcome_t allocator_outcome(logic [OP_W-1:0] op, int n, int h);
        outcome_t o;
        int len;
        int nh;
        o.st = ST_OK;
        o.page = 0;
        if (op == OP_ALLOC)
        begin
            if (n == 0)
                o.st = ST_NULL;
            else
            begin
                nh = first_fit(n);
                if (nh == 0)
                    o.st = ST_OOM;
                else
                begin
                    place_run(nh, n);
                    o.page = PAGE_W'(nh);
                end
            end
        end
        else if (op == OP_FREE || op == OP_RESIZE)
        begin
            if (h == 0)
                o.st = ST_NULL;
            else if (!pg_used[h] || !pg_head[h])
                o.st = ST_INVALID;
            else if (op == OP_FREE || n == 0)
                drop_run(h);
            else
            begin
                len = pg_run[h];
                if (n == len)
                    o.page = PAGE_W'(h);
                else if (n < len)
                begin
                    set_span(h + n, h + len, 0);
                    pg_run[h] = n;
                    o.page = PAGE_W'(h);
                end
                else if (span_free(h + len, h + n))
                begin
                    set_span(h + len, h + n, 1);
                    pg_run[h] = n;
                    o.page = PAGE_W'(h);
                end
                else
                begin
                    nh = first_fit(n);
                    if (nh == 0)
                        o.st = ST_OOM;
                    else
                    begin
                        place_run(nh, n);
                        drop_run(h);
                        o.page = PAGE_W'(nh);
                    end
                end
            end
        end
        else
            o.st = ST_NULL;
        count_free();
        o.nfree = COUNT_W'(free_total);
        return o;
    endfunction

    initial
    begin
        clk = 0;
        forever
            #6 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout at %0t", $time);
                $display("tb_first_fit_page_run_allocator: done, errors");
                $finish;
            end
        end
    end

    // Receiver: idles at random, or holds off for a long stretch on request.
    initial
    begin
        out_ready = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                hold_off--;
                out_ready <= 0;
            end
            else
                out_ready <= ($urandom_range(99) >= receiver_idle);
        end
    end

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_outcomes.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result st=%0d page=%0d free=%0d",
                         $time, status, result_page, free_pages);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (status !== want.st)
                begin
                    errors++;
                    $display("%0t: status expected %0d got %0d", $time, want.st, status);
                end
                if (result_page !== want.page)
                begin
                    errors++;
                    $display("%0t: result_page expected %0d got %0d",
                             $time, want.page, result_page);
                end
                if (free_pages !== want.nfree)
                begin
                    errors++;
                    $display("%0t: free_pages expected %0d got %0d",
                             $time, want.nfree, free_pages);
                end
            end
        end
    end

    task automatic send_request(logic [OP_W-1:0] op, int n, int h);
        outcome_t o;
        @(negedge clk);
        while ($urandom_range(99) < sender_idle)
            @(negedge clk);
        operation <= op;
        page_count <= COUNT_W'(n);
        head_page <= PAGE_W'(h);
        in_valid <= 1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        o = allocator_outcome(op, n, h);
        pending_outcomes.push_back(o);
        if (op == OP_ALLOC && o.page != 0)
            live_heads.push_back(o.page);
        if (op == OP_RESIZE && o.page != 0 && o.page != h)
            live_heads.push_back(o.page);
        @(negedge clk);
        in_valid <= 0;
    endtask

    task automatic drain();
        while (pending_outcomes.size() != 0)
            @(negedge clk);
        repeat (3 * NUM_PAGES + 20)
            @(negedge clk);
    endtask

    task automatic write_bound(logic idx, int value);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= CFG_W'(value);
        cfg_valid <= 1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_FIRST)
            bound_lo = CFG_W'(value);
        else
            bound_hi = CFG_W'(value);
        count_free();
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    function automatic int pick_head();
        int k;
        if (live_heads.size() == 0 || $urandom_range(9) == 0)
            return $urandom_range(NUM_PAGES - 1);
        k = $urandom_range(live_heads.size() - 1);
        return live_heads[k];
    endfunction

    task automatic random_requests(int total);
        int r;
        int n;
        for (int i = 0; i < total; i++)
        begin
            r = $urandom_range(99);
            if ($urandom_range(19) == 0)
                n = $urandom_range(2047);
            else
                n = $urandom_range(40);
            if (r < 45)
                send_request(OP_ALLOC, n, $urandom_range(NUM_PAGES - 1));
            else if (r < 70)
                send_request(OP_FREE, n, pick_head());
            else if (r < 97)
                send_request(OP_RESIZE, n, pick_head());
            else
                send_request(OP_NONE, n, $urandom_range(NUM_PAGES - 1));
        end
    endtask

    stim_row_t directed [] = '{
        '{OP_ALLOC,  11'd0,    10'd0,   1'b1, ST_NULL,    10'd0, 11'd1023},
        '{OP_ALLOC,  11'd1024, 10'd0,   1'b1, ST_OOM,     10'd0, 11'd1023},
        '{OP_ALLOC,  11'd2047, 10'h3ff, 1'b1, ST_OOM,     10'd0, 11'd1023},
        '{OP_ALLOC,  11'd1023, 10'd0,   1'b1, ST_OK,      10'd1, 11'd0},
        '{OP_ALLOC,  11'd1,    10'd0,   1'b1, ST_OOM,     10'd0, 11'd0},
        '{OP_FREE,   11'd0,    10'd0,   1'b1, ST_NULL,    10'd0, 11'd0},
        '{OP_FREE,   11'd0,    10'd2,   1'b1, ST_INVALID, 10'd0, 11'd0},
        '{OP_FREE,   11'd7,    10'd1,   1'b1, ST_OK,      10'd0, 11'd1023},
        '{OP_ALLOC,  11'd4,    10'd0,   1'b1, ST_OK,      10'd1, 11'd1019},
        '{OP_ALLOC,  11'd3,    10'd0,   1'b1, ST_OK,      10'd5, 11'd1016},
        '{OP_RESIZE, 11'd4,    10'd1,   1'b1, ST_OK,      10'd1, 11'd1016},
        '{OP_RESIZE, 11'd2,    10'd1,   1'b0, ST_OK,      10'd0, 11'd0},
        '{OP_RESIZE, 11'd4,    10'd1,   1'b0, ST_OK,      10'd0, 11'd0},
        '{OP_RESIZE, 11'd6,    10'd1,   1'b0, ST_OK,      10'd0, 11'd0},
        '{OP_RESIZE, 11'd6,    10'd5,   1'b0, ST_OK,      10'd0, 11'd0},
        '{OP_RESIZE, 11'd2000, 10'd1,   1'b0, ST_OK,      10'd0, 11'd0},
        '{OP_RESIZE, 11'd0,    10'd0,   1'b1, ST_NULL,    10'd0, 11'd1011},
        '{OP_RESIZE, 11'd0,    10'd1,   1'b0, ST_OK,      10'd0, 11'd0},
        '{OP_NONE,   11'h7ff,  10'h3ff, 1'b0, ST_OK,      10'd0, 11'd0},
        '{OP_FREE,   11'd0,    10'h3ff, 1'b0, ST_OK,      10'd0, 11'd0}
    };

    initial
    begin
        outcome_t o;
        rst_n = 0;
        in_valid = 0;
        operation = 0;
        page_count = 0;
        head_page = 0;
        cfg_valid = 0;
        cfg_index = 0;
        cfg_data = 0;
        errors = 0;
        results_seen = 0;
        hold_off = 0;
        sender_idle = 14;
        receiver_idle = 75;
        bound_lo = 1;
        bound_hi = 1023;
        for (int p = 0; p < NUM_PAGES; p++)
        begin
            pg_used[p] = 0;
            pg_head[p] = 0;
            pg_run[p] = 0;
        end
        count_free();
        repeat (2)
            @(negedge clk);
        rst_n = 1;

        foreach (directed[i])
        begin
            send_request(directed[i].op, directed[i].count, directed[i].head);
            o = pending_outcomes[pending_outcomes.size() - 1];
            if (directed[i].known && o != {directed[i].st, directed[i].page, directed[i].nfree})
            begin
                errors++;
                $display("%0t: table row %0d expected st=%0d page=%0d free=%0d, predicted %0d %0d %0d",
                         $time, i, directed[i].st, directed[i].page, directed[i].nfree,
                         o.st, o.page, o.nfree);
            end
        end
        drain();

        // Long receiver stall while requests keep coming.
        hold_off = 20000;
        random_requests(8);
        random_requests(180);
        drain();

        write_bound(CFG_FIRST, 0);
        write_bound(CFG_LAST, 1023);
        sender_idle = 75;
        receiver_idle = 14;
        random_requests(60);
        drain();
        write_bound(CFG_FIRST, 900);
        write_bound(CFG_LAST, 100);
        random_requests(20);
        drain();
        write_bound(CFG_FIRST, 513);
        write_bound(CFG_LAST, 682);
        random_requests(100);
        drain();
        write_bound(CFG_FIRST, 1023);
        write_bound(CFG_LAST, 1023);
        random_requests(20);
        drain();
        write_bound(CFG_FIRST, 1);
        write_bound(CFG_LAST, 1023);
        sender_idle = 0;
        receiver_idle = 0;
        random_requests(190);
        drain();

        $display("covered %0d results over the directed table and random traffic", results_seen);
        $display("bounds swept across empty, single-page, narrow and full windows");
        if (errors == 0 && pending_outcomes.size() == 0)
            $display("tb_first_fit_page_run_allocator: done, clean");
        else
            $display("tb_first_fit_page_run_allocator: done, errors");
        $finish;
    end
endmodule

// ----- first_fit_page_run_allocator.f -----
+incdir+rtl
rtl/ffpra_pkg.sv
rtl/ffpra_ram.sv
rtl/ffpra_datapath.sv
rtl/ffpra_ctrl.sv
rtl/first_fit_page_run_allocator.sv
bench/tb_first_fit_page_run_allocator.sv
